// ===== src/sgpg_pkg.sv =====
// sgpg_pkg: shared widths, constants, register codes and types for the
// stereo goniometer point generator. No dependencies.
package sgpg_pkg;

    // sample format and derived widths
    localparam int SAMPLE_BITS = 24;
    localparam int DIFF_W      = SAMPLE_BITS + 1;
    localparam int COEFF_W     = 16;
    localparam int GAIN_W      = 16;
    localparam int MOVE_W      = 16;
    localparam int COORD_W     = 16;

    // projection scale: 100 px per full scale, in 1/16 px
    localparam int SCALE       = 1600;
    localparam int SCALE_W     = 11;
    localparam int GS_W        = GAIN_W + SCALE_W;
    localparam int GAIN_FRAC   = 13;
    localparam int PROJ_SHIFT  = GAIN_FRAC + SAMPLE_BITS - 1;

    // product widths (signed)
    localparam int SM_PROD_W   = DIFF_W + COEFF_W + 1;
    localparam int PJ_PROD_W   = DIFF_W + GS_W + 1;
    localparam int V_W         = PJ_PROD_W - PROJ_SHIFT;
    localparam int CF_W        = V_W + 1;

    localparam logic [SM_PROD_W-1:0] SM_HALF = SM_PROD_W'(64'd1 << (COEFF_W - 1));
    localparam logic [PJ_PROD_W-1:0] PJ_HALF = PJ_PROD_W'(64'd1 << (PROJ_SHIFT - 1));

    // screen center (202.5 px) and coordinate limits
    localparam int CENTER      = 3240;
    localparam int COORD_MAX   = 32767;
    localparam int COORD_MIN   = -32768;

    // distance test
    localparam int DX_W        = COORD_W + 1;
    localparam int DIST_W      = 2 * DX_W;

    // stroke groups
    localparam int GROUP_LIMIT = 32;
    localparam int GC_W        = $clog2(GROUP_LIMIT + 1);

    // configuration registers
    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_COEFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MOVE_SQ  = 2'd2;

    localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd65365;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd8192;
    localparam logic [MOVE_W-1:0]  MOVE_RESET  = 16'd512;

    // per-step strobes from the sequencer
    typedef struct packed {
        logic smooth_mul;
        logic smooth_upd;
        logic proj_mul;
        logic proj_fin;
        logic dist_mul;
        logic decide;
    } step_t;

    // decision of the merge stage
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      kept;
        logic                      close;
        logic                      emit;
    } point_t;

    // display gain times the projection scale
    function automatic logic [GS_W-1:0] scale_gain(input logic [GAIN_W-1:0] g);
        return GS_W'(g) * GS_W'(SCALE);
    endfunction

endpackage

// ===== src/sgpg_smooth_lane.sv =====
// sgpg_smooth_lane: one-pole smoother for one audio channel, s += k*(in - s)
// with half-up rounding. Depends on sgpg_pkg.
module sgpg_smooth_lane
    import sgpg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  step_t                         step,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic        [COEFF_W-1:0]     coeff,
    output logic signed [SAMPLE_BITS-1:0] smoothed
);

    logic signed [SAMPLE_BITS-1:0] state_reg;
    logic signed [SAMPLE_BITS-1:0] state_next;
    logic signed [SM_PROD_W-1:0]   prod_reg;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [SM_PROD_W-1:0]   rounded;
    logic signed [DIFF_W-1:0]      delta;

    assign diff    = DIFF_W'(sample) - DIFF_W'(state_reg);
    assign rounded = (prod_reg + $signed(SM_HALF)) >>> COEFF_W;
    assign delta   = rounded[DIFF_W-1:0];
    // result lies between old state and sample, so it fits the sample width
    assign state_next = SAMPLE_BITS'(DIFF_W'(state_reg) + delta);

    always_ff @(posedge clk)
    begin
        if (step.smooth_mul)
        begin
            prod_reg <= diff * $signed({1'b0, coeff});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step.smooth_upd)
        begin
            state_reg <= state_next;
        end
    end

    assign smoothed = state_reg;

endmodule

// ===== src/sgpg_proj_lane.sv =====
// sgpg_proj_lane: projects a side or mid signal to a screen coordinate,
// rounded half up and saturated. Depends on sgpg_pkg.
module sgpg_proj_lane
    import sgpg_pkg::*;
(
    input  logic                      clk,
    input  step_t                     step,
    input  logic signed [DIFF_W-1:0]  operand,
    input  logic        [GS_W-1:0]    gain_scaled,
    output logic signed [COORD_W-1:0] coord
);

    logic signed [PJ_PROD_W-1:0] prod_reg;
    logic signed [PJ_PROD_W-1:0] shifted;
    logic signed [V_W-1:0]       v;
    logic signed [CF_W-1:0]      coord_full;
    logic signed [COORD_W-1:0]   coord_sat;
    logic signed [COORD_W-1:0]   coord_reg;

    assign shifted    = (prod_reg + $signed(PJ_HALF)) >>> PROJ_SHIFT;
    assign v          = shifted[V_W-1:0];
    assign coord_full = CF_W'(CENTER) - CF_W'(v);

    always_comb
    begin
        if (coord_full > CF_W'(COORD_MAX))
        begin
            coord_sat = COORD_W'(COORD_MAX);
        end
        else if (coord_full < CF_W'(COORD_MIN))
        begin
            coord_sat = COORD_W'(COORD_MIN);
        end
        else
        begin
            coord_sat = coord_full[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.proj_mul)
        begin
            prod_reg <= operand * $signed({1'b0, gain_scaled});
        end
        if (step.proj_fin)
        begin
            coord_reg <= coord_sat;
        end
    end

    assign coord = coord_reg;

endmodule

// ===== src/sgpg_point_select.sv =====
// sgpg_point_select: merges the x and y lanes, applies the minimum move
// test and tracks stroke groups. Depends on sgpg_pkg.
module sgpg_point_select
    import sgpg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  step_t                     step,
    input  logic signed [COORD_W-1:0] x,
    input  logic signed [COORD_W-1:0] y,
    input  logic        [MOVE_W-1:0]  min_move,
    input  logic                      batch_end,
    output point_t                    result
);

    logic signed [COORD_W-1:0] last_x_reg;
    logic signed [COORD_W-1:0] last_y_reg;
    logic        [GC_W-1:0]    group_cnt_reg;
    logic        [GC_W-1:0]    group_cnt_next;
    logic        [DIST_W-1:0]  sq_x_reg;
    logic        [DIST_W-1:0]  sq_y_reg;
    logic signed [DX_W-1:0]    dx;
    logic signed [DX_W-1:0]    dy;
    logic        [DIST_W-1:0]  dist_sq;
    logic        [GC_W:0]      cnt_inc;
    logic                      kept;
    logic                      close;

    assign dx = DX_W'(last_x_reg) - DX_W'(x);
    assign dy = DX_W'(last_y_reg) - DX_W'(y);

    always_ff @(posedge clk)
    begin
        if (step.dist_mul)
        begin
            sq_x_reg <= DIST_W'(dx * dx);
            sq_y_reg <= DIST_W'(dy * dy);
        end
    end

    assign dist_sq = sq_x_reg + sq_y_reg;
    assign kept    = dist_sq >= DIST_W'(min_move);
    assign cnt_inc = (GC_W + 1)'(group_cnt_reg) + (GC_W + 1)'(1);

    always_comb
    begin
        group_cnt_next = group_cnt_reg;
        close          = 1'b0;
        if (kept)
        begin
            if (cnt_inc > (GC_W + 1)'(GROUP_LIMIT))
            begin
                group_cnt_next = '0;
                close          = 1'b1;
            end
            else
            begin
                group_cnt_next = cnt_inc[GC_W-1:0];
            end
        end
        if (batch_end)
        begin
            if (group_cnt_next != '0)
            begin
                close = 1'b1;
            end
            group_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg    <= COORD_W'(CENTER);
            last_y_reg    <= COORD_W'(CENTER);
            group_cnt_reg <= '0;
        end
        else if (step.decide)
        begin
            if (kept)
            begin
                last_x_reg <= x;
                last_y_reg <= y;
            end
            group_cnt_reg <= group_cnt_next;
        end
    end

    assign result.x     = kept ? x : last_x_reg;
    assign result.y     = kept ? y : last_y_reg;
    assign result.kept  = kept;
    assign result.close = close;
    assign result.emit  = kept || close;

`ifndef SYNTH
    a_group_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        group_cnt_reg <= GC_W'(GROUP_LIMIT))
        else $error("group count above limit");

    a_group_counts_up: assert property (@(posedge clk) disable iff (!rst_n)
        (step.decide && kept && !close && !batch_end)
        |=> (group_cnt_reg == $past(group_cnt_reg) + GC_W'(1)))
        else $error("kept point did not advance group count");
`endif

endmodule

// ===== src/stereo_goniometer_point_generator.sv =====
// stereo_goniometer_point_generator: top level with configuration registers,
// step sequencer and output register. Depends on sgpg_pkg, sgpg_smooth_lane,
// sgpg_proj_lane and sgpg_point_select.

// Takes one stereo sample pair per input transfer and gives at most one point
// per pair. After its transfer a pair runs through the step sequencer states
// in order: smoothing multiply, smoothing update, projection multiply,
// rounding and saturation, squaring, decision. The decision loads an emitted
// result into the output register and returns to idle, where the next pair
// is taken, so a new pair is not accepted before the last one is through.
// Two smoother lanes (left, right) and two projection lanes (side for x, mid
// for y) each carry their own multiplier and run side by side; the point
// select stage merges the lanes, tests the squared move against min_move_sq
// and tracks stroke groups. The decision step waits while an earlier result
// still sits unread in the output register. Configuration writes are always
// taken (cfg_ready is tied high) and must only happen while the block is idle;
// writes to an index beyond the register list are ignored.
module stereo_goniometer_point_generator
    import sgpg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,

    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic        [CFG_IDX_W-1:0]   cfg_index,
    input  logic        [15:0]            cfg_data,

    // sample pair input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    input  logic                          batch_end,

    // point output
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_W-1:0]     point_x,
    output logic signed [COORD_W-1:0]     point_y,
    output logic                          point_kept,
    output logic                          close_group
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SMOOTH_MUL,
        ST_SMOOTH_UPD,
        ST_PROJ_MUL,
        ST_PROJ_FIN,
        ST_DIST_MUL,
        ST_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration registers; gain is kept pre-multiplied by the scale
    logic [COEFF_W-1:0] coeff_reg;
    logic [GS_W-1:0]    gain_scaled_reg;
    logic [MOVE_W-1:0]  move_reg;

    // captured input transfer
    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] right_reg;
    logic                          batch_reg;

    // output register
    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] point_x_reg;
    logic signed [COORD_W-1:0] point_y_reg;
    logic                      point_kept_reg;
    logic                      close_group_reg;

    step_t                         step;
    point_t                        result;
    logic                          in_fire;
    logic                          cfg_fire;
    logic                          out_free;
    logic signed [SAMPLE_BITS-1:0] smooth_l;
    logic signed [SAMPLE_BITS-1:0] smooth_r;
    logic signed [DIFF_W-1:0]      side;
    logic signed [DIFF_W-1:0]      mid;
    logic signed [COORD_W-1:0]     coord_x;
    logic signed [COORD_W-1:0]     coord_y;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    // decision may load the output register when it is empty or being read
    assign out_free  = !out_valid_reg || out_ready;

    // step strobes
    assign step.smooth_mul = (state_reg == ST_SMOOTH_MUL);
    assign step.smooth_upd = (state_reg == ST_SMOOTH_UPD);
    assign step.proj_mul   = (state_reg == ST_PROJ_MUL);
    assign step.proj_fin   = (state_reg == ST_PROJ_FIN);
    assign step.dist_mul   = (state_reg == ST_DIST_MUL);
    assign step.decide     = (state_reg == ST_DECIDE) && out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg       <= COEFF_RESET;
            gain_scaled_reg <= scale_gain(GAIN_RESET);
            move_reg        <= MOVE_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_SMOOTH_COEFF: coeff_reg       <= cfg_data[COEFF_W-1:0];
                REG_DISPLAY_GAIN: gain_scaled_reg <= scale_gain(cfg_data[GAIN_W-1:0]);
                REG_MIN_MOVE_SQ:  move_reg        <= cfg_data[MOVE_W-1:0];
                default:          ;
            endcase
        end
    end

    // capture the sample pair on its transfer
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            left_reg  <= left_sample;
            right_reg <= right_sample;
            batch_reg <= batch_end;
        end
    end

    // smoother lanes, one per channel
    sgpg_smooth_lane u_smooth_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .sample   (left_reg),
        .coeff    (coeff_reg),
        .smoothed (smooth_l)
    );

    sgpg_smooth_lane u_smooth_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .sample   (right_reg),
        .coeff    (coeff_reg),
        .smoothed (smooth_r)
    );

    // side drives x, mid drives y
    assign side = DIFF_W'(smooth_l) - DIFF_W'(smooth_r);
    assign mid  = DIFF_W'(smooth_l) + DIFF_W'(smooth_r);

    sgpg_proj_lane u_proj_x (
        .clk         (clk),
        .step        (step),
        .operand     (side),
        .gain_scaled (gain_scaled_reg),
        .coord       (coord_x)
    );

    sgpg_proj_lane u_proj_y (
        .clk         (clk),
        .step        (step),
        .operand     (mid),
        .gain_scaled (gain_scaled_reg),
        .coord       (coord_y)
    );

    // merge stage: move test and stroke groups
    sgpg_point_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .x         (coord_x),
        .y         (coord_y),
        .min_move  (move_reg),
        .batch_end (batch_reg),
        .result    (result)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SMOOTH_MUL;
                end
            end
            ST_SMOOTH_MUL: state_next = ST_SMOOTH_UPD;
            ST_SMOOTH_UPD: state_next = ST_PROJ_MUL;
            ST_PROJ_MUL:   state_next = ST_PROJ_FIN;
            ST_PROJ_FIN:   state_next = ST_DIST_MUL;
            ST_DIST_MUL:   state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            point_x_reg     <= '0;
            point_y_reg     <= '0;
            point_kept_reg  <= 1'b0;
            close_group_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (step.decide && result.emit)
            begin
                out_valid_reg   <= 1'b1;
                point_x_reg     <= result.x;
                point_y_reg     <= result.y;
                point_kept_reg  <= result.kept;
                close_group_reg <= result.close;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign point_kept  = point_kept_reg;
    assign close_group = close_group_reg;

`ifndef SYNTH
    a_result_meaningful: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (point_kept_reg || close_group_reg))
        else $error("result carries neither a point nor a group close");

    a_decide_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && out_valid_reg && !out_ready)
        |=> (state_reg == ST_DECIDE && $stable(point_x_reg) && $stable(point_y_reg)))
        else $error("decision overran an unread result");

    a_gain_scaled: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_index == REG_DISPLAY_GAIN)
        |=> (gain_scaled_reg == scale_gain($past(cfg_data))))
        else $error("scaled gain does not follow display gain write");
`endif

endmodule

// ===== test/tb_stereo_goniometer_point_generator.sv =====
// tb_stereo_goniometer_point_generator: self-checking testbench for the goniometer
// point generator, with a scoreboard class that predicts each point from the sample pairs.
// Depends on sgpg_pkg and stereo_goniometer_point_generator.
module tb_stereo_goniometer_point_generator
    import sgpg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // handshake pacing and run limits
    localparam int MAX_IDLE      = 14;
    localparam int DRAIN_CYCLES  = 20;
    localparam int SETTLE_LIMIT  = 4000;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_PAIRS   = 250;
    localparam int PICK_RANDOM   = -1;

    // config index past the register list, must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_ONE = 1;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_NEG = -1;

    // one expected point as it should leave the block
    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      kept;
        logic                      close;
    } point_rec_t;

    // shadow of the smoothers, the last kept point, the stroke group and the registers
    class point_scoreboard;
        longint     smooth_l;
        longint     smooth_r;
        longint     last_x;
        longint     last_y;
        int         group_cnt;
        longint     coeff;
        longint     gain;
        longint     min_move;
        point_rec_t pending_points[$];
        int         fails;

        function new();
            smooth_l  = 0;
            smooth_r  = 0;
            last_x    = CENTER;
            last_y    = CENTER;
            group_cnt = 0;
            coeff     = COEFF_RESET;
            gain      = GAIN_RESET;
            min_move  = MOVE_RESET;
            fails     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                REG_SMOOTH_COEFF: coeff = data;
                REG_DISPLAY_GAIN: gain = data;
                REG_MIN_MOVE_SQ:  min_move = data;
                default: ;
            endcase
        endfunction

        // s + round(k * (in - s) / 2^16), ties toward plus infinity
        function longint smooth_step(longint s, longint sample);
            longint d;
            d = sample - s;
            return s + ((d * coeff + (longint'(1) << (COEFF_W - 1))) >>> COEFF_W);
        endfunction

        // center minus the rounded, scaled projection, clamped to 16 bits
        function longint project(longint d);
            longint p;
            longint c;
            p = gain * d * SCALE;
            c = CENTER - ((p + (longint'(1) << (PROJ_SHIFT - 1))) >>> PROJ_SHIFT);
            if (c > COORD_MAX)
                c = COORD_MAX;
            if (c < COORD_MIN)
                c = COORD_MIN;
            return c;
        endfunction

        function void note_pair(logic signed [SAMPLE_BITS-1:0] l,
                                logic signed [SAMPLE_BITS-1:0] r, logic be);
            longint     x;
            longint     y;
            longint     dx;
            longint     dy;
            bit         kept;
            bit         close;
            point_rec_t rec;
            smooth_l = smooth_step(smooth_l, longint'(l));
            smooth_r = smooth_step(smooth_r, longint'(r));
            x  = project(smooth_l - smooth_r);
            y  = project(smooth_l + smooth_r);
            dx = last_x - x;
            dy = last_y - y;
            kept  = (dx * dx + dy * dy) >= min_move;
            close = 1'b0;
            if (kept)
            begin
                last_x = x;
                last_y = y;
                group_cnt++;
                if (group_cnt > GROUP_LIMIT)
                begin
                    group_cnt = 0;
                    close     = 1'b1;
                end
            end
            if (be)
            begin
                if (group_cnt > 0)
                    close = 1'b1;
                group_cnt = 0;
            end
            if (kept || close)
            begin
                rec.x     = COORD_W'(last_x);
                rec.y     = COORD_W'(last_y);
                rec.kept  = kept;
                rec.close = close;
                pending_points.push_back(rec);
            end
        endfunction

        function void check_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                  logic kept, logic close);
            point_rec_t want;
            if (pending_points.size() == 0)
            begin
                $error("unexpected point: point_x %0d point_y %0d", x, y);
                fails++;
                return;
            end
            want = pending_points.pop_front();
            if (x !== want.x)
            begin
                $error("point_x: expected %0d, actual %0d", want.x, x);
                fails++;
            end
            if (y !== want.y)
            begin
                $error("point_y: expected %0d, actual %0d", want.y, y);
                fails++;
            end
            if (kept !== want.kept)
            begin
                $error("point_kept: expected %0d, actual %0d", want.kept, kept);
                fails++;
            end
            if (close !== want.close)
            begin
                $error("close_group: expected %0d, actual %0d", want.close, close);
                fails++;
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic        [CFG_IDX_W-1:0]   cfg_index = '0;
    logic        [15:0]            cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] left_sample = '0;
    logic signed [SAMPLE_BITS-1:0] right_sample = '0;
    logic                          batch_end = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [COORD_W-1:0]     point_x;
    logic signed [COORD_W-1:0]     point_y;
    logic                          point_kept;
    logic                          close_group;

    point_scoreboard point_board;
    int unsigned     cycle_count = 0;

    // when set, a side draws random idle gaps; when clear it runs back to back
    bit in_lazy  = 1'b1;
    bit out_lazy = 1'b1;

    // per-phase register settings for the random part, PICK_RANDOM draws a fresh value
    int coeff_tab[RANDOM_PHASES] = '{65535, PICK_RANDOM, 0, 2048, 65365, PICK_RANDOM};
    int gain_tab[RANDOM_PHASES]  = '{8192, PICK_RANDOM, 49152, 49152, 0, PICK_RANDOM};
    int move_tab[RANDOM_PHASES]  = '{0, PICK_RANDOM, 0, 512, 0, PICK_RANDOM};

    stereo_goniometer_point_generator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .batch_end    (batch_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_kept   (point_kept),
        .close_group  (close_group)
    );

    always #1 clk = ~clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("stereo_goniometer_point_generator: mismatch");
        $finish;
    end

    // register write transfer; the scoreboard copy follows on acceptance
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        point_board.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_setting(input int coeff_v, input int gain_v, input int move_v);
        write_reg(REG_SMOOTH_COEFF,
                  (coeff_v == PICK_RANDOM) ? 16'($urandom_range(0, 65535)) : 16'(coeff_v));
        write_reg(REG_DISPLAY_GAIN,
                  (gain_v == PICK_RANDOM) ? 16'($urandom_range(0, 65535)) : 16'(gain_v));
        write_reg(REG_MIN_MOVE_SQ,
                  (move_v == PICK_RANDOM) ? 16'($urandom_range(0, 65535)) : 16'(move_v));
    endtask

    // one sample pair transfer; valid stays high into the next pair when no gap is drawn
    task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] l,
                             input logic signed [SAMPLE_BITS-1:0] r, input logic be);
        int gap;
        gap = in_lazy ? $urandom_range(0, MAX_IDLE) : 0;
        if ($urandom_range(0, 39) == 0)
            in_lazy = !in_lazy;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        left_sample  <= l;
        right_sample <= r;
        batch_end    <= be;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        point_board.note_pair(l, r, be);
    endtask

    // wait until every predicted point is out, then let a pair that makes no point finish
    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (point_board.pending_points.size() != 0 && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly small or full-scale audio, some rail values
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return SAMPLE_MAX;
                1:       return SAMPLE_MIN;
                2:       return '0;
                default: return SAMPLE_NEG;
            endcase
        end
        if (sel < 3)
            return SAMPLE_BITS'(int'($urandom_range(0, 8191)) - 4096);
        if (sel < 5)
            return SAMPLE_BITS'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        return SAMPLE_BITS'($urandom);
    endfunction

    task automatic send_random_pair();
        logic signed [SAMPLE_BITS-1:0] l;
        logic signed [SAMPLE_BITS-1:0] r;
        int unsigned                   shape;
        l     = pick_sample();
        shape = $urandom_range(0, 7);
        // mono (no side) and anti-phase (no mid) signals pin one axis at center
        if (shape == 0)
            r = l;
        else if (shape == 1)
            r = -l;
        else
            r = pick_sample();
        send_pair(l, r, $urandom_range(0, 15) == 0);
    endtask

    // point sink: random stalls per point, checked against the oldest prediction
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = out_lazy ? $urandom_range(0, MAX_IDLE) : 0;
            if ($urandom_range(0, 39) == 0)
                out_lazy = !out_lazy;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            point_board.check_point(point_x, point_y, point_kept, close_group);
        end
    end

    initial
    begin
        point_board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: unit gain, light smoothing, small move threshold
        send_pair('0, '0, 1'b1);                // batch end on an empty group
        send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0); // large jump along the mid axis
        send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0); // settled, move below threshold
        send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b1); // no move but batch end closes the group
        send_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1); // kept point on a batch end
        send_pair(SAMPLE_NEG, SAMPLE_ONE, 1'b0);
        settle();

        // no smoothing, full-range gain, every point kept; stray index must do nothing
        write_setting(65535, 49152, 0);
        write_reg(REG_UNUSED, 16'hffff);
        send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
        send_pair('0, '0, 1'b0);
        send_pair(SAMPLE_ONE, SAMPLE_NEG, 1'b1);
        send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        settle();

        // frozen smoother, gain past 6, widest move threshold
        write_setting(0, 65535, 65535);
        send_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0); // gain jump alone moves the point
        send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b0); // frozen, no move
        send_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b1); // close only
        send_pair('0, '0, 1'b1);                // group already empty
        settle();

        // random part, one register setting per phase
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_setting(coeff_tab[ph], gain_tab[ph], move_tab[ph]);
            for (int n = 0; n < PHASE_PAIRS; n++)
                send_random_pair();
            settle();
        end

        if (point_board.pending_points.size() != 0)
        begin
            $error("%0d expected points never came out", point_board.pending_points.size());
            point_board.fails++;
        end
        if (point_board.fails == 0)
            $display("stereo_goniometer_point_generator: match");
        else
            $display("stereo_goniometer_point_generator: mismatch");
        $finish;
    end

endmodule
